FILE: src/bfskm_pkg.sv
// Shared types, constants and the sine lookup table of the binary FSK modulator.
// No dependencies; every other source file of the block imports this package.
package bfskm_pkg;

  localparam int MSG_LEN_DEF = 32;
  localparam int TABLE_LEN   = 83;
  localparam int TAB_W       = $clog2(TABLE_LEN);
  localparam int SAMPLE_W    = 12;
  localparam int IDX_W       = 5;

  // Command codes carried in the cmd field.
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [IDX_W-1:0] bit_index;
    logic             bit_value;
    logic             timer_id;
  } in_item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                symbol_end;
    logic                message_end;
  } out_item_t;

  typedef logic [TABLE_LEN-1:0][SAMPLE_W-1:0] sine_rom_t;

  // Fixed-point constants of the table generator (angles in Q30).
  localparam longint          Q30_ONE      = 64'sd1073741824;
  localparam longint unsigned PI_Q30       = 64'd3373259426;
  localparam longint unsigned HALF_PI_Q30  = 64'd1686629713;
  localparam longint unsigned TWO_PI_MICRO = 64'd6283184;
  localparam longint unsigned MICRO        = 64'd1000000;
  localparam longint unsigned TAYLOR_DIV [8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                                 64'd110, 64'd156, 64'd210, 64'd272};

  // One table entry: 2048 * (1 + sin(2 pi i / TABLE_LEN)), evaluated with a
  // truncated Taylor series in Q30. Only ever evaluated during elaboration.
  function automatic logic [SAMPLE_W-1:0] sine_entry(input int unsigned idx);
    longint unsigned theta;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned v;
    longint          sum;
    longint          u;
    logic            neg;
    theta = ((TWO_PI_MICRO * longint'(idx)) << 30) / (MICRO * TABLE_LEN);
    neg   = 1'b0;
    if (theta >= PI_Q30) begin
      theta = theta - PI_Q30;
      neg   = 1'b1;
    end
    if (theta > HALF_PI_Q30) begin
      theta = (theta >= PI_Q30) ? 64'd0 : PI_Q30 - theta;
    end
    x2   = (theta * theta) >> 30;
    term = theta;
    sum  = longint'(theta);
    for (int k = 1; k <= 8; k++) begin
      term = (term * x2) >> 30;
      term = term / TAYLOR_DIV[k-1];
      if ((k & 1) != 0) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    u = neg ? (Q30_ONE - sum) : (Q30_ONE + sum);
    if (u < 0) begin
      u = 0;
    end
    v = longint'(u) >> 19;
    if (v > 64'd4095) begin
      v = 64'd4095;
    end
    return v[SAMPLE_W-1:0];
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    for (int i = 0; i < TABLE_LEN; i++) begin
      rom[i] = sine_entry(i);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

FILE: src/bfskm_msg_mem.sv
// Message bit store: a one-bit-wide synchronous memory, one write and one read port.
// Read data is registered; a write to the address being read is forwarded.
module bfskm_msg_mem #(
  parameter int MSG_LEN = bfskm_pkg::MSG_LEN_DEF,
  parameter int AW      = 5
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic          wr_bit,
  input  logic [AW-1:0] rd_addr,
  output logic          rd_bit
);
  import bfskm_pkg::*;

  logic mem [MSG_LEN];
  logic rd_bit_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_bit_r <= wr_bit;
    end else begin
      rd_bit_r <= mem[rd_addr];
    end
  end

  assign rd_bit = rd_bit_r;

endmodule

FILE: src/bfskm_seq.sv
// Modulator sequencer: command decode, bit/table/cycle counters and sample lookup.
// Uses bfskm_pkg for the item types, command codes and the sine table.
module bfskm_seq #(
  parameter int MSG_LEN = bfskm_pkg::MSG_LEN_DEF,
  parameter int AW      = 5
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                take,
  input  bfskm_pkg::in_item_t item,
  input  logic                cur_bit,
  output logic                wr_en,
  output logic [AW-1:0]       wr_addr,
  output logic                wr_bit,
  output logic [AW-1:0]       rd_addr,
  output logic                res_valid,
  output bfskm_pkg::out_item_t res
);
  import bfskm_pkg::*;

  localparam int IW = (AW > IDX_W) ? AW : IDX_W;

  logic             sending_r, sending_nxt;
  logic [AW-1:0]    bit_pos_r, bit_pos_nxt;
  logic [TAB_W-1:0] tab_pos_r, tab_pos_nxt;
  logic             cyc_r, cyc_nxt;
  logic [IW-1:0]    idx_ext;
  logic             idx_ok;

  assign idx_ext = IW'(item.bit_index);
  assign idx_ok  = (int'(item.bit_index) < MSG_LEN);
  assign wr_addr = idx_ext[AW-1:0];
  assign wr_bit  = item.bit_value;
  // The store is read at the position the next beat will use, so the current
  // bit is always waiting in the read register.
  assign rd_addr = bit_pos_nxt;

  always_comb begin
    sending_nxt = sending_r;
    bit_pos_nxt = bit_pos_r;
    tab_pos_nxt = tab_pos_r;
    cyc_nxt     = cyc_r;
    wr_en       = 1'b0;
    res_valid   = 1'b0;
    res         = '0;
    if (take) begin
      unique case (item.cmd)
        CMD_LOAD: begin
          wr_en = !sending_r && idx_ok;
        end
        CMD_START: begin
          if (!sending_r) begin
            sending_nxt = 1'b1;
            bit_pos_nxt = '0;
            tab_pos_nxt = '0;
            cyc_nxt     = 1'b0;
          end
        end
        CMD_TICK: begin
          if (sending_r && (cur_bit == item.timer_id)) begin
            res_valid  = 1'b1;
            res.sample = SINE_ROM[tab_pos_r];
            if (tab_pos_r == TAB_W'(TABLE_LEN - 1)) begin
              tab_pos_nxt = '0;
              // A one lasts a single table cycle, a zero lasts two.
              if (cur_bit || cyc_r) begin
                cyc_nxt        = 1'b0;
                res.symbol_end = 1'b1;
                if (bit_pos_r == AW'(MSG_LEN - 1)) begin
                  bit_pos_nxt     = '0;
                  sending_nxt     = 1'b0;
                  res.message_end = 1'b1;
                end else begin
                  bit_pos_nxt = bit_pos_r + 1'b1;
                end
              end else begin
                cyc_nxt = 1'b1;
              end
            end else begin
              tab_pos_nxt = tab_pos_r + 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sending_r <= 1'b0;
      bit_pos_r <= '0;
      tab_pos_r <= '0;
      cyc_r     <= 1'b0;
    end else begin
      sending_r <= sending_nxt;
      bit_pos_r <= bit_pos_nxt;
      tab_pos_r <= tab_pos_nxt;
      cyc_r     <= cyc_nxt;
    end
  end

endmodule

FILE: src/bfskm_out_buf.sv
// Result output register with one skid entry behind it.
// Uses bfskm_pkg for the result item type.
module bfskm_out_buf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 res_valid,
  input  bfskm_pkg::out_item_t res,
  output logic                 full,
  output logic                 out_valid,
  input  logic                 out_stall,
  output bfskm_pkg::out_item_t out_data
);
  import bfskm_pkg::*;

  logic      out_v_r, out_v_nxt;
  logic      skid_v_r, skid_v_nxt;
  out_item_t out_d_r, out_d_nxt;
  out_item_t skid_d_r, skid_d_nxt;
  logic      out_take;

  assign out_take  = out_v_r && !out_stall;
  assign full      = skid_v_r;
  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

  always_comb begin
    out_v_nxt  = out_v_r;
    skid_v_nxt = skid_v_r;
    out_d_nxt  = out_d_r;
    skid_d_nxt = skid_d_r;
    if (skid_v_r) begin
      // No new result can arrive while the skid entry is occupied.
      if (out_take) begin
        out_d_nxt  = skid_d_r;
        skid_v_nxt = 1'b0;
      end
    end else if (res_valid) begin
      if (!out_v_r || out_take) begin
        out_d_nxt = res;
        out_v_nxt = 1'b1;
      end else begin
        skid_d_nxt = res;
        skid_v_nxt = 1'b1;
      end
    end else if (out_take) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r  <= out_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

endmodule

FILE: src/bfsk_sine_modulator_core.sv
// Binary FSK modulator, top level. Load message bits by index, send a start command,
// then feed timer ticks; each tick from the timer matching the current bit yields the
// next 12-bit sine sample, a one lasting one table cycle and a zero two. One beat is
// accepted every clock cycle unless the input is stalled: the command is decoded and the
// counters updated in the cycle it is accepted, and its sample is registered at that
// same edge, in the output register or, if that holds a waiting result, in the skid
// entry. The message bits sit in a single-bit synchronous memory that is read every
// cycle at the position the next beat will use, with same-address writes forwarded,
// so no tick ever waits for it. An output register plus one skid entry lets the input
// keep flowing while a result waits; the input stalls only when both are full.
// Depends on bfskm_pkg, bfskm_msg_mem, bfskm_seq and bfskm_out_buf.
module bfsk_sine_modulator_core #(
  parameter int MSG_LEN = bfskm_pkg::MSG_LEN_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  bfskm_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output bfskm_pkg::out_item_t out_data
);
  import bfskm_pkg::*;

  localparam int AW = (MSG_LEN > 1) ? $clog2(MSG_LEN) : 1;

  logic          take;
  logic          cur_bit;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic          wr_bit;
  logic [AW-1:0] rd_addr;
  logic          res_valid;
  out_item_t     res;
  logic          full;

  assign in_stall = full;
  assign take     = in_valid && !full;

  bfskm_msg_mem #(
    .MSG_LEN (MSG_LEN),
    .AW      (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_bit  (wr_bit),
    .rd_addr (rd_addr),
    .rd_bit  (cur_bit)
  );

  bfskm_seq #(
    .MSG_LEN (MSG_LEN),
    .AW      (AW)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .item      (in_data),
    .cur_bit   (cur_bit),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_bit    (wr_bit),
    .rd_addr   (rd_addr),
    .res_valid (res_valid),
    .res       (res)
  );

  bfskm_out_buf u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: src/bfskm_checker.sv
// Port-level checks for the binary FSK modulator, bound to the top level.
// Depends on bfskm_pkg and bfsk_sine_modulator_core.
module bfskm_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input bfskm_pkg::in_item_t  in_data,
  input logic                 out_valid,
  input logic                 out_stall,
  input bfskm_pkg::out_item_t out_data
);
  import bfskm_pkg::*;

  // A stalled result beat holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  // The end of the message is always the end of a symbol too.
  a_msg_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_data.message_end || out_data.symbol_end))
    else $error("message end without symbol end");

  // The input only backs up behind a result that is waiting.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result pending");

  // Reset empties the result side.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("result buffer not empty after reset");

endmodule

bind bfsk_sine_modulator_core bfskm_checker u_bfskm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
